// ----- hw/rtl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W = 24;
    localparam int SUM_W = 21;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [10:0] RESET_WIDTH  = 11'd640;
    localparam logic [15:0] RESET_HEIGHT = 16'd480;
    localparam logic [10:0] PEND_MAX     = 11'd2047;
    localparam logic [15:0] ROW_MAX      = 16'hFFFF;
    localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65281;
    localparam logic [7:0] MAG_MAX = 8'd255;

    typedef logic [8:0][PIX_W-1:0] win_t;

    typedef struct packed {
        win_t win;
        logic last;
    } qentry_t;

    typedef enum logic {
        FS_IDLE,
        FS_EXEC
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_GRAD,
        BS_SQX,
        BS_SQY,
        BS_ROOT,
        BS_ROUND,
        BS_OUT
    } back_state_t;

endpackage

// ----- hw/rtl/sem_front.sv -----
// ----------------------------------------------------------------------------
// sem_front
// Takes pixel and drain words, runs the line store and the 3x3 window, and
// queues one window snapshot per owed result.
// ----------------------------------------------------------------------------
module sem_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic [23:0]      in_pix,
    input  logic [10:0]      frame_width,
    input  logic [15:0]      frame_height,
    output logic             q_wr,
    output sem_pkg::qentry_t q_data,
    input  logic             q_full
);
    import sem_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    front_state_t     state_reg, state_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [15:0]      row_reg, row_next;
    logic [10:0]      pend_reg, pend_next;
    win_t             win_reg, win_next;
    logic [PIX_W-1:0] pix_reg;
    logic             full_reg;
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic             accept, full_now, ignore;
    logic [WW-1:0]    eff_w;
    logic [CW:0]      c_inc;
    logic [PIX_W-1:0] up, lo;
    logic             emit, go, last;
    logic [10:0]      p1;
    win_t             outwin;

    assign in_ready = (state_reg == FS_IDLE);
    assign accept   = in_valid && in_ready;
    assign full_now = row_reg >= frame_height;
    assign ignore   = full_now ? (pend_reg == 11'd0) : (in_op == OP_DRAIN);

    // effective width: clamp to 1..MAX_WIDTH
    always_comb begin
        if (frame_width == 11'd0) begin
            eff_w = WW'(1);
        end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width);
        end
    end

    // line store: {upper, lower} per column
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= mem[col_reg];
        end
        if (state_reg == FS_EXEC && go) begin
            mem[col_reg] <= {lo, pix_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg  <= full_now ? '0 : in_pix;
            full_reg <= full_now;
        end
    end

    always_comb begin
        up    = (row_reg >= 16'd2) ? rd_reg[2*PIX_W-1:PIX_W] : '0;
        lo    = (row_reg >= 16'd1) ? rd_reg[PIX_W-1:0] : '0;
        emit  = (row_reg >= 16'd2) || (row_reg == 16'd1 && col_reg != '0);
        go    = !emit || !q_full;
        c_inc = {1'b0, col_reg} + (CW+1)'(1);

        win_next = win_reg;
        outwin   = '0;
        for (int r = 0; r < 3; r++) begin
            if (col_reg == '0) begin
                outwin[r*3+0]   = win_reg[r*3+1];
                outwin[r*3+1]   = win_reg[r*3+2];
                win_next[r*3+0] = '0;
                win_next[r*3+1] = '0;
            end else begin
                win_next[r*3+0] = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
        end
        win_next[2] = up;
        win_next[5] = lo;
        win_next[8] = pix_reg;
        if (col_reg != '0) begin
            outwin = win_next;
        end

        col_next = (32'(c_inc) >= 32'(eff_w)) ? '0 : c_inc[CW-1:0];
        row_next = row_reg;
        if (col_next == '0 && row_reg < ROW_MAX) begin
            row_next = row_reg + 16'd1;
        end

        p1 = (!full_reg && pend_reg < PEND_MAX) ? pend_reg + 11'd1 : pend_reg;
        pend_next = p1;
        if (emit && p1 != 11'd0) begin
            pend_next = p1 - 11'd1;
        end
        last = emit && full_reg && pend_next == 11'd0;
        if (last) begin
            row_next = '0;
            col_next = '0;
            win_next = '0;
        end

        q_wr        = (state_reg == FS_EXEC) && go && emit;
        q_data.win  = outwin;
        q_data.last = last;

        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (accept && !ignore) begin
                    state_next = FS_EXEC;
                end
            end
            FS_EXEC: begin
                if (go) begin
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == FS_EXEC && go) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                pend_reg <= pend_next;
                win_reg  <= win_next;
            end
        end
    end

endmodule

// ----- hw/rtl/sem_fifo.sv -----
// ----------------------------------------------------------------------------
// sem_fifo
// Two-entry queue of window snapshots between front and back.
// ----------------------------------------------------------------------------
module sem_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr,
    input  sem_pkg::qentry_t wr_data,
    output logic             full,
    input  logic             rd,
    output sem_pkg::qentry_t rd_data,
    output logic             empty
);
    import sem_pkg::*;

    qentry_t    slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            case ({wr, rd})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/sem_back.sv -----
// ----------------------------------------------------------------------------
// sem_back
// Per channel: Sobel gradients, squared sum, bit-serial rounded root.
// Holds the result word in the output register.
// ----------------------------------------------------------------------------
module sem_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  sem_pkg::qentry_t q_data,
    output logic             q_rd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [23:0]      out_data,
    output logic             out_last
);
    import sem_pkg::*;

    back_state_t       state_reg, state_next;
    win_t              win_reg;
    logic              last_reg;
    logic [1:0]        ch_reg;
    logic [9:0]        ax_reg, ay_reg;
    logic [SUM_W-1:0]  s_reg;
    logic [7:0]        q_reg, bit_reg;
    logic [2:0][7:0]   mag_reg;
    logic              ov_reg;
    logic [23:0]       od_reg;
    logic              ol_reg;

    logic [8:0][7:0]   p;
    logic signed [11:0] gx, gy;
    logic [7:0]        t;
    logic [15:0]       tt;
    logic [16:0]       qq;
    logic [8:0]        qr;
    logic              load_out;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;
    assign q_rd      = (state_reg == BS_IDLE) && !q_empty;

    // channel 0 is red (top byte)
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            case (ch_reg)
                2'd0:    p[i] = win_reg[i][23:16];
                2'd1:    p[i] = win_reg[i][15:8];
                default: p[i] = win_reg[i][7:0];
            endcase
        end
        gx = (12'(p[2]) + 12'(p[8]) + {3'b0, p[5], 1'b0})
           - (12'(p[0]) + 12'(p[6]) + {3'b0, p[3], 1'b0});
        gy = (12'(p[6]) + 12'(p[8]) + {3'b0, p[7], 1'b0})
           - (12'(p[0]) + 12'(p[2]) + {3'b0, p[1], 1'b0});
        t  = q_reg | bit_reg;
        tt = 16'(t) * 16'(t);
        qq = 17'(q_reg) * 17'(q_reg) + 17'(q_reg);
        if (s_reg >= SAT_LIMIT) begin
            qr = 9'(MAG_MAX);
        end else if (21'(qq) < s_reg) begin
            qr = 9'(q_reg) + 9'd1;
        end else begin
            qr = 9'(q_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            BS_IDLE:  if (!q_empty) state_next = BS_GRAD;
            BS_GRAD:  state_next = BS_SQX;
            BS_SQX:   state_next = BS_SQY;
            BS_SQY:   state_next = BS_ROOT;
            BS_ROOT:  if (bit_reg[0]) state_next = BS_ROUND;
            BS_ROUND: state_next = (ch_reg == 2'd2) ? BS_OUT : BS_GRAD;
            BS_OUT: begin
                if (!ov_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = BS_IDLE;
                end
            end
            default:  state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BS_IDLE: begin
                win_reg  <= q_data.win;
                last_reg <= q_data.last;
                ch_reg   <= 2'd0;
            end
            BS_GRAD: begin
                ax_reg <= 10'(gx[11] ? -gx : gx);
                ay_reg <= 10'(gy[11] ? -gy : gy);
            end
            BS_SQX: s_reg <= SUM_W'(20'(ax_reg) * 20'(ax_reg));
            BS_SQY: begin
                s_reg   <= s_reg + SUM_W'(20'(ay_reg) * 20'(ay_reg));
                q_reg   <= '0;
                bit_reg <= 8'h80;
            end
            BS_ROOT: begin
                if (SUM_W'(tt) <= s_reg) q_reg <= t;
                bit_reg <= bit_reg >> 1;
            end
            BS_ROUND: begin
                mag_reg[ch_reg] <= qr[8] ? MAG_MAX : qr[7:0];
                ch_reg <= ch_reg + 2'd1;
            end
            default: ;
        endcase
        if (load_out) begin
            // tdata: red low byte, then green, then blue
            od_reg <= {mag_reg[2], mag_reg[1], mag_reg[0]};
            ol_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BS_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/sobel_edge_magnitude_rgb_top.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_top
// Streaming 3x3 Sobel gradient magnitude on RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order (s_tuser = 0); each channel is filtered on its
// own with the Sobel Gx/Gy kernels, zero outside the frame, and gives
// round(sqrt(gx^2+gy^2)) clamped to 255. A result leaves width+1 words after
// its pixel; once the frame is in, drain words (s_tuser = 1, or any word
// after the last pixel) release what is left, and the frame's final result
// has m_tlast set, after which a new frame starts. The front reads the line
// store when it takes a word and updates the window before it takes the
// next; words that give nothing skip the update. It waits while the queue
// is full. Per channel the back runs the gradient, two squares, 8 root
// steps and rounding; it takes the word from the queue first, loads the
// output register last and waits there while m_tready is low. A two-word
// queue lets the front run ahead of the back. frame_width/frame_height
// take effect at once and should only be written between frames.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_edge, green_edge, blue_edge
    output logic        m_tlast,   // frame_last
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import sem_pkg::*;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        q_wr, q_full, q_rd, q_empty;
    qentry_t     q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // internal pixel: red in the top byte
    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_pix       ({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_wr         (q_wr),
        .q_data       (q_in),
        .q_full       (q_full)
    );

    sem_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_data (q_in),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_out),
        .empty   (q_empty)
    );

    sem_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_rd      (q_rd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- hw/rtl/sem_checker.sv -----
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks of the Sobel block, bound to the top level.
// ----------------------------------------------------------------------------
module sem_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // nothing can follow the frame's last result at once
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result right after frame end");

endmodule

bind sobel_edge_magnitude_rgb_top sem_checker u_sem_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
// Frames of random size are streamed in with random gaps on the input side
// and random back-pressure on the output side. An in-bench model of the
// line stores and window predicts every edge word. Results are checked in
// order, field by field. Geometry registers change only between frames.
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving
    localparam int SETTLE_CYCLES = 150;
    localparam int RANDOM_ITEMS = 900;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_word_t;

    // Edge predictor plus in-order store of expected words.
    class edge_scoreboard;
        int kx[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
        int ky[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
        logic [10:0] width_reg;
        logic [15:0] height_reg;
        logic [23:0] row_up[LINE_DEPTH];
        logic [23:0] row_lo[LINE_DEPTH];
        logic [23:0] win[9];
        int unsigned col;
        int unsigned row;
        int unsigned owed;
        edge_word_t expected_q[$];
        int mismatches;

        function void clear();
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            foreach (win[i]) win[i] = '0;
            col = 0;
            row = 0;
            owed = 0;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_FRAME_WIDTH) width_reg = val[10:0];
            else height_reg = val;
        endfunction

        function int unsigned round_root(int unsigned s);
            int unsigned q;
            int unsigned t;
            q = 0;
            if (s >= 65281) return 255;
            for (int b = 7; b >= 0; b--) begin
                t = q | (1 << b);
                if (t * t <= s) q = t;
            end
            if (s > q * q + q) q++;
            return (q > 255) ? 255 : q;
        endfunction

        function logic [7:0] chan_mag(logic [23:0] w[9], int sh);
            int gx;
            int gy;
            int v;
            gx = 0;
            gy = 0;
            for (int i = 0; i < 9; i++) begin
                v = (w[i] >> sh) & 255;
                gx += kx[i] * v;
                gy += ky[i] * v;
            end
            return 8'(round_root(gx * gx + gy * gy));
        endfunction

        // Accepted input word; returns 1 when it releases the frame's last result.
        function bit note_input(logic op, logic [23:0] pix);
            int unsigned w;
            int unsigned c;
            int unsigned idx;
            int unsigned nc;
            bit full;
            bit emit;
            bit last;
            logic [23:0] up;
            logic [23:0] lo;
            logic [23:0] ow[9];
            edge_word_t e;
            w = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
            full = row >= height_reg;
            c = col;
            idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
            if (!full && op == OP_DRAIN) return 0;
            if (full) begin
                if (owed == 0) return 0;
                pix = '0;
            end
            up = (row >= 2) ? row_up[idx] : '0;
            lo = (row >= 1) ? row_lo[idx] : '0;
            row_up[idx] = lo;
            row_lo[idx] = pix;
            emit = (row >= 2) || (row == 1 && c >= 1);
            if (c == 0) begin
                // close previous row with a zero column, restart the window
                for (int r = 0; r < 3; r++) begin
                    ow[r*3] = win[r*3+1];
                    ow[r*3+1] = win[r*3+2];
                    ow[r*3+2] = '0;
                    win[r*3] = '0;
                    win[r*3+1] = '0;
                end
            end else begin
                for (int r = 0; r < 3; r++) begin
                    win[r*3] = win[r*3+1];
                    win[r*3+1] = win[r*3+2];
                end
            end
            win[2] = up;
            win[5] = lo;
            win[8] = pix;
            if (c != 0) ow = win;
            nc = (c + 1 >= w) ? 0 : c + 1;
            col = nc;
            if (nc == 0 && row < 16'hFFFF) row++;
            if (!full && owed < PEND_MAX) owed++;
            if (!emit) return 0;
            if (owed > 0) owed--;
            last = full && owed == 0;
            e.red = chan_mag(ow, 16);
            e.green = chan_mag(ow, 8);
            e.blue = chan_mag(ow, 0);
            e.last = last;
            expected_q.push_back(e);
            if (last) begin
                row = 0;
                col = 0;
                foreach (win[i]) win[i] = '0;
            end
            return last;
        endfunction

        function void check_result(logic [23:0] data, logic last);
            edge_word_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected edge word data=%h last=%b", data, last);
                return;
            end
            e = expected_q.pop_front();
            if (data !== {e.blue, e.green, e.red} || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("edge mismatch: exp r=%0d g=%0d b=%0d last=%b, got r=%0d g=%0d b=%0d last=%b",
                             e.red, e.green, e.blue, e.last,
                             data[7:0], data[15:8], data[23:16], last);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    edge_scoreboard sb;
    bit gaps_on;        // random idling on both sides
    bit running;        // reset released
    int quiet_cycles;
    int stall_left;
    int random_items;

    sobel_edge_magnitude_rgb_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Receiver: random stall bursts, checks every accepted word.
    always @(posedge aclk) begin
        if (running && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles where no word moves on either side.
    always @(posedge aclk) begin
        if (running) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[sobel_edge_magnitude_rgb_top] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    // One word on the input stream; last tells if it closed the frame.
    task automatic send_word(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             output bit last);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        last = sb.note_input(op, {r, g, b});
    endtask

    // Let the block run dry before touching the registers.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random frame: pixels with stray drains during fill, then drains/pushes
    // until the frame's last word is released.
    task automatic run_frame(logic [15:0] w, logic [15:0] h, output int used);
        int px_left;
        int eff;
        bit last;
        logic op;
        logic [23:0] v;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        eff = (w == 0) ? 1 : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
        px_left = eff * h;
        used = 0;
        last = 0;
        while (!last) begin
            if (px_left > 0) begin
                op = ($urandom_range(0, 9) == 0) ? OP_DRAIN : OP_PUSH;
                if (op == OP_PUSH) px_left--;
            end else begin
                op = 1'($urandom_range(0, 1));  // a push after fill acts as a drain
            end
            used++;
            v = $urandom;
            send_word(op, v[7:0], v[15:8], v[23:16], last);
        end
    endtask

    initial begin
        int used;
        bit last;
        logic [23:0] v;
        sb = new();
        sb.clear();
        running = 0;
        gaps_on = 1;
        quiet_cycles = 0;
        stall_left = 0;
        random_items = 0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_PUSH;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        running = 1;
        @(posedge aclk);

        // register extremes, height overwritten before any pixel
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(CFG_FRAME_WIDTH, 16'd1024);

        // height zero: everything ignored
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        send_word(OP_PUSH, 8'hFF, 8'h00, 8'hFF, last);
        send_word(OP_DRAIN, 8'h00, 8'hFF, 8'h00, last);
        send_word(OP_PUSH, 8'h00, 8'h00, 8'h00, last);

        // 3x3 checkerboard of full/zero pixels, saturating magnitudes
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        send_word(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF, last);   // drain during fill
        for (int i = 0; i < 9; i++) begin
            v = (i % 2) ? 24'hFFFFFF : 24'h000000;
            send_word(OP_PUSH, v[7:0], v[15:8], v[23:16], last);
        end
        last = 0;
        while (!last) send_word(OP_PUSH, 8'hAA, 8'h55, 8'hAA, last); // push after fill

        // short frame: fewer pixels than width+1
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd5);
        write_reg(CFG_FRAME_HEIGHT, 16'd1);
        for (int i = 0; i < 5; i++) send_word(OP_PUSH, 8'hFF, 8'h00, 8'h7F, last);
        last = 0;
        while (!last) send_word(OP_DRAIN, 8'h00, 8'h00, 8'h00, last);

        // width zero clamps to one
        run_frame(16'd0, 16'd4, used);

        // random frames, mostly small
        while (random_items < RANDOM_ITEMS) begin
            if (random_items > RANDOM_ITEMS - 120) gaps_on = 0;
            case ($urandom_range(0, 9))
                0: run_frame(16'($urandom_range(17, 64)), 16'($urandom_range(1, 3)), used);
                1: run_frame(16'd1, 16'($urandom_range(1, 8)), used);
                default: run_frame(16'($urandom_range(1, 16)), 16'($urandom_range(1, 8)),
                                   used);
            endcase
            random_items += used;
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[sobel_edge_magnitude_rgb_top] OK");
        end else begin
            $display("[sobel_edge_magnitude_rgb_top] ERROR");
        end
        $finish;
    end
endmodule
